// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising edge outside reset
`define HBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define HBP_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/hbp_pkg.sv =====
// types and constants of the text bits / hex byte parser
// no dependencies
package hbp_pkg;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;

	typedef enum logic [0:0] {
		CFG_MODE,
		CFG_CAPACITY
	} hbp_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FORMAT,
		ST_FULL
	} hbp_status_t;

	typedef enum logic [2:0] {
		K_SPACE,
		K_HASH,
		K_NEWLINE,
		K_BIT,
		K_HEX,
		K_OTHER
	} hbp_kind_t;

	typedef struct packed {
		logic      start;
		hbp_kind_t kind;
		logic [3:0] nibble;
	} hbp_item_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic        byte_ready;
		logic [1:0]  status;
		logic [15:0] bytes_count;
	} hbp_result_t;

endpackage

// ===== rtl/hbp_queue.sv =====
// two-entry queue of requests, used between the parser stages and at the output
// depends on nothing
module hbp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/hbp_front.sv =====
// front end: takes characters, classifies them and queues them for the back end
// depends on hbp_pkg and hbp_queue
module hbp_front
	import hbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic [7:0] char_code,
	input  logic      stream_start,
	output logic      full,
	output hbp_item_t item,
	output logic      item_valid,
	input  logic      item_take
);

	hbp_item_t cls;
	logic      is_dec;
	logic      is_lower;
	logic      is_upper;
	logic      q_empty;

	always_comb begin
		is_dec   = (char_code >= 8'h30) && (char_code <= 8'h39);
		is_lower = (char_code >= 8'h61) && (char_code <= 8'h66);
		is_upper = (char_code >= 8'h41) && (char_code <= 8'h46);
		cls.start  = stream_start;
		cls.nibble = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;
		priority if (char_code == CH_SPACE) begin
			cls.kind = K_SPACE;
		end else if (char_code == CH_HASH) begin
			cls.kind = K_HASH;
		end else if (char_code == CH_NEWLINE) begin
			cls.kind = K_NEWLINE;
		end else if (char_code == CH_ZERO || char_code == CH_ONE) begin
			cls.kind = K_BIT;
		end else if (is_dec || is_lower || is_upper) begin
			cls.kind = K_HEX;
		end else begin
			cls.kind = K_OTHER;
		end
	end

	hbp_queue #(.WIDTH($bits(hbp_item_t))) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cls),
		.full   (full),
		.pop    (item_take),
		.dout   (item),
		.empty  (q_empty)
	);

	assign item_valid = !q_empty;

endmodule

// ===== rtl/hbp_back.sv =====
// back end: stream state, byte assembly, status and the result queue
// depends on hbp_pkg and hbp_queue
module hbp_back
	import hbp_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  hbp_item_t   item,
	input  logic        item_valid,
	output logic        item_take,
	input  logic        parse_mode,
	input  logic [15:0] capacity,
	input  logic        res_pop,
	output hbp_result_t res,
	output logic        res_empty
);

	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                   in_comment_q;
	logic [2:0]             digit_pos_q;
	logic [7:0]             partial_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   format_err_q;
	logic                   stopped_q;

	logic                   cm;
	logic [2:0]             dp;
	logic [7:0]             pb;
	logic [COUNT_WIDTH-1:0] cnt;
	logic                   fe;
	logic                   sf;
	logic                   rdy;
	logic [7:0]             val;
	logic [CMP_W-1:0]       cnt_ext;
	logic [CMP_W-1:0]       cap_ext;
	logic                   res_full;
	hbp_result_t            res_new;

	assign item_take = item_valid && !res_full;

	always_comb begin
		cm  = in_comment_q;
		dp  = digit_pos_q;
		pb  = partial_q;
		cnt = count_q;
		fe  = format_err_q;
		sf  = stopped_q;
		rdy = 1'b0;
		val = 8'd0;
		if (item.start) begin
			cm  = 1'b0;
			dp  = 3'd0;
			pb  = 8'd0;
			cnt = '0;
			fe  = 1'b0;
			sf  = 1'b0;
		end
		cnt_ext = CMP_W'(cnt);
		cap_ext = CMP_W'(capacity);
		if (!fe && !sf) begin
			priority if (cnt_ext == cap_ext || cnt == CNT_MAX) begin
				sf = 1'b1;
			end else if (cm) begin
				if (item.kind == K_NEWLINE) begin
					cm = 1'b0;
				end
			end else if (item.kind == K_SPACE || item.kind == K_HASH ||
				item.kind == K_NEWLINE) begin
				if (dp != 3'd0) begin
					fe = 1'b1;
				end else if (item.kind == K_HASH) begin
					cm = 1'b1;
				end
			end else if (!parse_mode) begin
				if (item.kind == K_BIT) begin
					pb = {pb[6:0], item.nibble[0]};
					if (dp == 3'd7) begin
						rdy = 1'b1;
						val = pb;
						dp  = 3'd0;
						pb  = 8'd0;
					end else begin
						dp = dp + 3'd1;
					end
				end
			end else begin
				if (item.kind == K_OTHER) begin
					fe = 1'b1;
				end else begin
					pb = {pb[3:0], item.nibble};
					if (dp != 3'd0) begin
						rdy = 1'b1;
						val = pb;
						dp  = 3'd0;
						pb  = 8'd0;
					end else begin
						dp = 3'd1;
					end
				end
			end
			if (rdy) begin
				cnt = cnt + COUNT_WIDTH'(1);
			end
		end
		res_new.byte_value  = val;
		res_new.byte_ready  = rdy;
		res_new.status      = fe ? ST_FORMAT : (sf ? ST_FULL : ST_OK);
		res_new.bytes_count = 16'(CMP_W'(cnt));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			digit_pos_q  <= 3'd0;
			partial_q    <= 8'd0;
			count_q      <= '0;
			format_err_q <= 1'b0;
			stopped_q    <= 1'b0;
		end else if (item_take) begin
			in_comment_q <= cm;
			digit_pos_q  <= dp;
			partial_q    <= pb;
			count_q      <= cnt;
			format_err_q <= fe;
			stopped_q    <= sf;
		end
	end

	hbp_queue #(.WIDTH($bits(hbp_result_t))) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_take),
		.din    (res_new),
		.full   (res_full),
		.pop    (res_pop),
		.dout   (res),
		.empty  (res_empty)
	);

endmodule

// ===== rtl/text_bits_hex_byte_parser.sv =====
// an accepted character is registered in the front queue, then the back end updates its state and queues the result
// throughput: one character per cycle while the result queue is not full, set by the state update in the back end
// two-entry queues between front and back and at the output let each side stall alone
// reset: queues empty, stream state cleared, parse_mode 0, capacity 65535
// depends on hbp_pkg, hbp_front, hbp_back and assert_macros.svh
module text_bits_hex_byte_parser
	import hbp_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        stream_start,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  byte_value,
	output logic        byte_ready,
	output logic [1:0]  status,
	output logic [15:0] bytes_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        mode_q;
	logic [15:0] capacity_q;
	hbp_item_t   item;
	logic        item_valid;
	logic        item_take;
	hbp_result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			capacity_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q     <= cfg_data[0];
				CFG_CAPACITY: capacity_q <= cfg_data;
				default:      mode_q     <= mode_q;
			endcase
		end
	end

	hbp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.char_code    (char_code),
		.stream_start (stream_start),
		.full         (full),
		.item         (item),
		.item_valid   (item_valid),
		.item_take    (item_take)
	);

	hbp_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.parse_mode (mode_q),
		.capacity   (capacity_q),
		.res_pop    (pop),
		.res        (res),
		.res_empty  (empty)
	);

	assign byte_value  = res.byte_value;
	assign byte_ready  = res.byte_ready;
	assign status      = res.status;
	assign bytes_count = res.bytes_count;

`include "assert_macros.svh"

	`HBP_ASSERT(a_ready_ok, !empty && byte_ready |-> status == ST_OK, "byte with bad status")
	`HBP_NEVER(a_idle_value, !empty && !byte_ready && byte_value != 8'd0, "stray byte value")

endmodule
